>>> sv/deq_pkg.sv
// shared types and constants for the double-ended queue core
package deq_pkg;

	// default ring capacity
	localparam int CAPACITY_DEF = 64;

	// field widths
	localparam int DATA_W = 32;
	localparam int CMD_W = 3;
	localparam int OCC_W = 7;
	localparam int STAT_W = 2;
	localparam int RES_W = DATA_W + OCC_W + STAT_W;
	localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;
	localparam int OUT_PAD_W = OUT_TDATA_W - RES_W;

	// command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_READ_OUT   = 3'd4,
		CMD_COUNT      = 3'd5
	} cmd_t;

	// status codes
	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	// result load request from control to the output stage
	typedef struct packed {
		logic             load;
		logic             from_mem;
		logic [OCC_W-1:0] occupancy;
		status_t          status;
		logic             last;
	} res_req_t;

endpackage

>>> sv/deq_ram.sv
// ring store: one write port, one registered read port
module deq_ram #(
	parameter int DEPTH = deq_pkg::CAPACITY_DEF,
	parameter int ADDR_W = $clog2(deq_pkg::CAPACITY_DEF),
	parameter int DATA_W = deq_pkg::DATA_W
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/deq_ctrl.sv
// command decode, ring pointers and read-out sequencer
module deq_ctrl #(
	parameter int CAPACITY = deq_pkg::CAPACITY_DEF,
	parameter int IDX_W = $clog2(CAPACITY),
	parameter int CNT_W = $clog2(CAPACITY + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// input stream
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [deq_pkg::CMD_W-1:0] in_cmd,
	// ring store access
	output logic                    ram_we,
	output logic [IDX_W-1:0]        ram_waddr,
	output logic                    ram_re,
	output logic [IDX_W-1:0]        ram_raddr,
	// output stage
	input  logic                    out_free,
	output deq_pkg::res_req_t       res
);

	localparam int SUM_W = CNT_W + 1;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	state_t                state_q;
	logic [IDX_W-1:0]      front_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [IDX_W-1:0]      rd_ptr_q;
	logic [CNT_W-1:0]      rd_left_q;
	logic                  mem_valid_s1;
	logic                  mem_last_s1;

	logic                  accept;
	logic                  full;
	logic                  empty;
	logic [IDX_W-1:0]      front_dec;
	logic [IDX_W-1:0]      front_inc;
	logic [IDX_W-1:0]      rd_ptr_inc;
	logic [SUM_W-1:0]      back_sum;
	logic [IDX_W-1:0]      back_pos;
	logic                  push_ok;
	logic                  start_rd;
	logic [IDX_W-1:0]      front_nx;
	logic [CNT_W-1:0]      cnt_nx;
	deq_pkg::status_t      stat;
	deq_pkg::cmd_t         cmd;

	assign cmd = deq_pkg::cmd_t'(in_cmd);

	// a new command waits until the read-out pipe is empty and the output stage has room
	assign in_ready = (state_q == ST_IDLE) && !mem_valid_s1 && out_free;
	assign accept = in_valid && in_ready;

	assign full = (cnt_q == CNT_W'(CAPACITY));
	assign empty = (cnt_q == '0);

	// ring index arithmetic modulo capacity
	assign front_dec = (front_q == '0) ? IDX_W'(CAPACITY - 1) : front_q - 1'b1;
	assign front_inc = (front_q == IDX_W'(CAPACITY - 1)) ? '0 : front_q + 1'b1;
	assign rd_ptr_inc = (rd_ptr_q == IDX_W'(CAPACITY - 1)) ? '0 : rd_ptr_q + 1'b1;
	assign back_sum = SUM_W'(front_q) + SUM_W'(cnt_q);
	assign back_pos = (back_sum >= SUM_W'(CAPACITY)) ?
		IDX_W'(back_sum - SUM_W'(CAPACITY)) : IDX_W'(back_sum);

	// command decode
	always_comb begin
		push_ok = 1'b0;
		start_rd = 1'b0;
		front_nx = front_q;
		cnt_nx = cnt_q;
		stat = deq_pkg::STAT_OK;
		ram_waddr = front_dec;
		unique case (cmd)
			deq_pkg::CMD_PUSH_FRONT: begin
				if (full) begin
					stat = deq_pkg::STAT_FULL;
				end else begin
					push_ok = 1'b1;
					front_nx = front_dec;
					cnt_nx = cnt_q + 1'b1;
				end
			end
			deq_pkg::CMD_PUSH_BACK: begin
				ram_waddr = back_pos;
				if (full) begin
					stat = deq_pkg::STAT_FULL;
				end else begin
					push_ok = 1'b1;
					cnt_nx = cnt_q + 1'b1;
				end
			end
			deq_pkg::CMD_POP_FRONT: begin
				if (empty) begin
					stat = deq_pkg::STAT_EMPTY;
				end else begin
					front_nx = front_inc;
					cnt_nx = cnt_q - 1'b1;
				end
			end
			deq_pkg::CMD_POP_BACK: begin
				if (empty) begin
					stat = deq_pkg::STAT_EMPTY;
				end else begin
					cnt_nx = cnt_q - 1'b1;
				end
			end
			deq_pkg::CMD_READ_OUT: begin
				if (empty) begin
					stat = deq_pkg::STAT_EMPTY;
				end else begin
					start_rd = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign ram_we = accept && push_ok;

	// read issue in the read state whenever the stage after the memory can move on
	assign ram_re = (state_q == ST_READ) && (!mem_valid_s1 || out_free);
	assign ram_raddr = rd_ptr_q;

	// result to the output stage: memory data has priority, a command only when idle
	always_comb begin
		res.load = (accept && !start_rd) || (mem_valid_s1 && out_free);
		res.from_mem = mem_valid_s1;
		res.occupancy = mem_valid_s1 ? deq_pkg::OCC_W'(cnt_q) : deq_pkg::OCC_W'(cnt_nx);
		res.status = mem_valid_s1 ? deq_pkg::STAT_OK : stat;
		res.last = mem_valid_s1 ? mem_last_s1 : 1'b1;
	end

	// state, pointers and read pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			front_q <= '0;
			cnt_q <= '0;
			rd_ptr_q <= '0;
			rd_left_q <= '0;
			mem_valid_s1 <= 1'b0;
			mem_last_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						front_q <= front_nx;
						cnt_q <= cnt_nx;
						if (start_rd) begin
							state_q <= ST_READ;
							rd_ptr_q <= front_q;
							rd_left_q <= cnt_q;
						end
					end
				end
				ST_READ: begin
					if (ram_re) begin
						rd_ptr_q <= rd_ptr_inc;
						rd_left_q <= rd_left_q - 1'b1;
						if (rd_left_q == CNT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (ram_re) begin
				mem_valid_s1 <= 1'b1;
				mem_last_s1 <= (rd_left_q == CNT_W'(1));
			end else if (mem_valid_s1 && out_free) begin
				mem_valid_s1 <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	// occupancy never exceeds the ring size
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("element count above capacity");

	// a push never lands while a read-out is in flight
	a_no_write_during_read: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_IDLE) && !mem_valid_s1)
		else $error("ring write during read-out");

	// the output stage is loaded only when it has room
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		res.load |-> out_free)
		else $error("result loaded into a busy output stage");

	// issuing the final read returns to idle with the last flag in the pipe
	a_last_issue: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re && (rd_left_q == CNT_W'(1)) |=> (state_q == ST_IDLE) && mem_last_s1)
		else $error("read-out did not end on its last element");
`endif

endmodule

>>> sv/deq_out.sv
// output register stage for result transfers
module deq_out (
	input  logic                              clk,
	input  logic                              arst_n,
	input  deq_pkg::res_req_t                 res,
	input  logic [deq_pkg::DATA_W-1:0]        mem_data,
	output logic                              free,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [deq_pkg::OUT_TDATA_W-1:0]   out_data,
	output logic                              out_last
);

	logic                         valid_q;
	logic [deq_pkg::DATA_W-1:0]   item_q;
	logic [deq_pkg::OCC_W-1:0]    occ_q;
	deq_pkg::status_t             status_q;
	logic                         last_q;

	// room for a new result when empty or when the current one transfers now
	assign free = !valid_q || out_ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res.load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// result fields
	always_ff @(posedge clk) begin
		if (res.load) begin
			item_q <= res.from_mem ? mem_data : '0;
			occ_q <= res.occupancy;
			status_q <= res.status;
			last_q <= res.last;
		end
	end

	assign out_valid = valid_q;
	assign out_data = {{deq_pkg::OUT_PAD_W{1'b0}}, status_q, occ_q, item_q};
	assign out_last = last_q;

endmodule

>>> sv/double_ended_queue_core.sv
// top level of the bounded double-ended queue
//
//  channel  dir  tdata                          tuser      tlast
//  s_axis   in   value[31:0]                    cmd[2:0]   -
//  m_axis   out  item, occupancy, status        -          last
//
//  push, pop, count, unused codes and read-out of an empty queue: one transfer in, one result the next cycle
//  read-out of n elements: n results, one per cycle while m_axis takes them; the first
//  leaves after the read pass starts, through the ring store read register and the result register
//  the next command is taken after the last read-out element has left the read stage
//  reset clears pointers and count at once; store contents are undefined until pushed
//  a stall on m_axis holds the read-out in place without losing elements
module double_ended_queue_core #(
	parameter int CAPACITY = deq_pkg::CAPACITY_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [deq_pkg::DATA_W-1:0]          s_axis_tdata,  // value[31:0]
	input  logic [deq_pkg::CMD_W-1:0]           s_axis_tuser,  // cmd[2:0]
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [deq_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // item[31:0], occupancy[38:32],
	                                                           // status[40:39], zero pad
	output logic                                m_axis_tlast
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic                        ram_we;
	logic [IDX_W-1:0]            ram_waddr;
	logic                        ram_re;
	logic [IDX_W-1:0]            ram_raddr;
	logic [deq_pkg::DATA_W-1:0]  ram_rdata;
	logic                        out_free;
	deq_pkg::res_req_t           res;

	// command decode and pointers
	deq_ctrl #(
		.CAPACITY (CAPACITY),
		.IDX_W    (IDX_W),
		.CNT_W    (CNT_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cmd    (s_axis_tuser),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.out_free  (out_free),
		.res       (res)
	);

	// ring store
	deq_ram #(
		.DEPTH  (CAPACITY),
		.ADDR_W (IDX_W),
		.DATA_W (deq_pkg::DATA_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (s_axis_tdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// result register
	deq_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.mem_data  (ram_rdata),
		.free      (out_free),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule
